### design/tsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants of the timestamp stream merger: the command and
// result transfers, the classified operation passed from front to back, and
// the command and configuration register codes.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_END  = 2'd1;
  localparam logic [1:0] CMD_POP  = 2'd2;

  localparam logic [1:0] CFG_OFFSET_SEC = 2'd0;
  localparam logic [1:0] CFG_OFFSET_NS  = 2'd1;
  localparam logic [1:0] CFG_UNTIMED    = 2'd2;

  localparam logic [32:0] NS_PER_SEC = 33'd1000000000;
  localparam logic [4:0]  UNTIMED_RESET = 5'd12;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  stream_index;
    logic [31:0] seconds;
    logic [29:0] nanoseconds;
    logic [4:0]  service;
    logic [31:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  source_stream;
    logic [31:0] out_seconds;
    logic [29:0] out_nanoseconds;
    logic [4:0]  out_service;
    logic [31:0] out_stamp;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_END  = 2'd1,
    OP_POP  = 2'd2
  } op_e;

  typedef struct packed {
    op_e         kind;
    logic [2:0]  idx;
    logic [31:0] sec;
    logic [29:0] ns;
    logic [4:0]  svc;
    logic [31:0] stamp;
  } op_t;

endpackage
`default_nettype wire

### design/timestamp_stream_merger.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_stream_merger
// Merges up to STREAMS record streams by timestamp through one head per stream.
// ----------------------------------------------------------------------------
// The front end takes one command transfer per cycle while its two-entry
// queue has room; the back end applies load and end commands directly.
// On a pop the back end scans the head store one entry per cycle through
// its single read port, keeping the earliest valid head (lowest stream wins
// ties), and then writes the result register, which holds a finished result
// while the next command is queued. Loads whose service code differs from
// the untimed code get the configured offset added on entry. Commands with
// code 3, and loads or ends to a stream at or above STREAMS, are dropped.
// ----------------------------------------------------------------------------
module timestamp_stream_merger #(
  parameter int STREAMS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire tsm_pkg::in_item_t  in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      tsm_pkg::out_item_t out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i
);
  import tsm_pkg::*;

  logic push_valid;
  logic push_ready;
  op_t  push_data;
  logic pop_valid;
  logic pop_ready;
  op_t  pop_data;

  tsm_front #(
    .STREAMS(STREAMS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  tsm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  tsm_back #(
    .STREAMS(STREAMS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (pop_valid),
    .q_ready_o  (pop_ready),
    .q_data_i   (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

### design/tsm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_front
// Command front end: holds the configuration registers, drops unused and
// out-of-range commands, applies the time offset to loads and pushes the
// classified operation to the queue.
// ----------------------------------------------------------------------------
module tsm_front #(
  parameter int STREAMS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire tsm_pkg::in_item_t in_data_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_data_i,
  output      logic              push_valid_o,
  input  wire logic              push_ready_i,
  output      tsm_pkg::op_t      push_data_o
);
  import tsm_pkg::*;

  logic [31:0] off_sec_q;
  logic [30:0] off_ns_q;
  logic [4:0]  untimed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_sec_q <= '0;
      off_ns_q  <= '0;
      untimed_q <= UNTIMED_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFFSET_SEC: off_sec_q <= cfg_data_i;
        CFG_OFFSET_NS:  off_ns_q  <= cfg_data_i[30:0];
        CFG_UNTIMED:    untimed_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic        in_range;
  logic        keep;
  logic [32:0] ns_sum;
  logic [32:0] ns_minus;
  logic [32:0] ns_plus;
  logic [31:0] sec_base;
  logic [31:0] sec_inc;
  logic [31:0] sec_dec;
  logic [31:0] sec_adj;
  logic [29:0] ns_adj;

  assign in_range = int'(in_data_i.stream_index) < STREAMS;

  always_comb begin
    case (in_data_i.command)
      CMD_LOAD, CMD_END: keep = in_range;
      CMD_POP:           keep = 1'b1;
      default:           keep = 1'b0;
    endcase
  end

  assign ns_sum   = {3'b000, in_data_i.nanoseconds} + {{2{off_ns_q[30]}}, off_ns_q};
  assign ns_minus = {3'b000, in_data_i.nanoseconds} + {{2{off_ns_q[30]}}, off_ns_q}
                    - NS_PER_SEC;
  assign ns_plus  = {3'b000, in_data_i.nanoseconds} + {{2{off_ns_q[30]}}, off_ns_q}
                    + NS_PER_SEC;
  assign sec_base = in_data_i.seconds + off_sec_q;
  assign sec_inc  = in_data_i.seconds + off_sec_q + 32'd1;
  assign sec_dec  = in_data_i.seconds + off_sec_q + 32'hFFFF_FFFF;

  always_comb begin
    if (in_data_i.service == untimed_q) begin
      sec_adj = in_data_i.seconds;
      ns_adj  = in_data_i.nanoseconds;
    end else if (ns_sum[32]) begin
      sec_adj = sec_dec;
      ns_adj  = ns_plus[29:0];
    end else if (!ns_minus[32]) begin
      sec_adj = sec_inc;
      ns_adj  = ns_minus[29:0];
    end else begin
      sec_adj = sec_base;
      ns_adj  = ns_sum[29:0];
    end
  end

  always_comb begin
    push_data_o.idx   = in_data_i.stream_index;
    push_data_o.sec   = sec_adj;
    push_data_o.ns    = ns_adj;
    push_data_o.svc   = in_data_i.service;
    push_data_o.stamp = in_data_i.stamp;
    case (in_data_i.command)
      CMD_LOAD: push_data_o.kind = OP_LOAD;
      CMD_END:  push_data_o.kind = OP_END;
      default:  push_data_o.kind = OP_POP;
    endcase
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && keep;

endmodule
`default_nettype wire

### design/tsm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_queue
// Two-entry operation queue between front end and back end.
// ----------------------------------------------------------------------------
module tsm_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output      logic         push_ready_o,
  input  wire tsm_pkg::op_t push_data_i,
  output      logic         pop_valid_o,
  input  wire logic         pop_ready_i,
  output      tsm_pkg::op_t pop_data_o
);
  import tsm_pkg::*;

  op_t        slot_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_data_o   = slot_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/tsm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_back
// Back end: stream head store, earliest-head scan over the store's read port
// and the result register.
// ----------------------------------------------------------------------------
module tsm_back #(
  parameter int STREAMS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  output      logic               q_ready_o,
  input  wire tsm_pkg::op_t       q_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      tsm_pkg::out_item_t out_data_o
);
  import tsm_pkg::*;

  localparam int IW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int CW = $clog2(STREAMS + 1) > 0 ? $clog2(STREAMS + 1) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(STREAMS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  typedef struct packed {
    logic [31:0] sec;
    logic [29:0] ns;
    logic [4:0]  svc;
    logic [31:0] stamp;
  } head_t;

  head_t mem_q [STREAMS];
  head_t rd_q;
  head_t best_q, best_d;
  head_t mem_wdata;
  logic  mem_we;

  logic [STREAMS-1:0] head_valid_q, head_valid_d;
  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]      cmp_idx_q, cmp_idx_d;
  logic               found_q, found_d;
  logic [IW-1:0]      best_idx_q, best_idx_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic [IW-1:0]      widx;

  assign widx      = IW'(q_data_i.idx);
  assign mem_wdata = '{sec: q_data_i.sec, ns: q_data_i.ns, svc: q_data_i.svc,
                       stamp: q_data_i.stamp};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[widx] <= mem_wdata;
    end
    rd_q <= mem_q[cnt_q[IW-1:0]];
  end

  always_comb begin
    q_ready_o    = 1'b0;
    mem_we       = 1'b0;
    head_valid_d = head_valid_q;
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    if (cmp_vld_q && (!found_q || {rd_q.sec, rd_q.ns} < {best_q.sec, best_q.ns})) begin
      found_d    = 1'b1;
      best_d     = rd_q;
      best_idx_d = cmp_idx_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_data_i.kind)
            OP_LOAD: begin
              mem_we             = 1'b1;
              head_valid_d[widx] = 1'b1;
              q_ready_o          = 1'b1;
            end
            OP_END: begin
              head_valid_d[widx] = 1'b0;
              q_ready_o          = 1'b1;
            end
            OP_POP: begin
              state_d = ST_SCAN;
              cnt_d   = '0;
              found_d = 1'b0;
            end
            default: q_ready_o = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_q < CNT_LAST) begin
          cnt_d     = cnt_q + CW'(1);
          cmp_vld_d = head_valid_q[cnt_q[IW-1:0]];
          cmp_idx_d = cnt_q[IW-1:0];
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          q_ready_o   = 1'b1;
          state_d     = ST_IDLE;
          if (found_q) begin
            out_d = '{status: 1'b0, source_stream: 3'(best_idx_q),
                      out_seconds: best_q.sec, out_nanoseconds: best_q.ns,
                      out_service: best_q.svc, out_stamp: best_q.stamp};
            head_valid_d[best_idx_q] = 1'b0;
          end else begin
            out_d = '{status: 1'b1, default: '0};
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= '0;
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      cmp_vld_q    <= cmp_vld_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_done_is_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (q_valid_i && q_data_i.kind == OP_POP))
    else $error("scan finished without a pop at the queue head");

  a_best_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && found_q) |-> head_valid_q[best_idx_q])
    else $error("selected head is not valid");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("pop result left the back end while the result register was full");
`endif

endmodule
`default_nettype wire
